// ===== rtl/core/json_string_escaper_unit_defines.svh =====
// ---------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_UNIT_DEFINES_SVH
`define JSON_STRING_ESCAPER_UNIT_DEFINES_SVH

// Same-cycle implication
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jse_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper package
// Payload types, descriptor format, character codes and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse_pkg;

	localparam int INDEX_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int POS_W          = 16;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int SEQ_W          = 3;
	localparam int ESC_MAX        = 6;

	// Register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_START    = 1'b1;

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	typedef enum logic [1:0] {
		ST_BYTE     = 2'd0,
		ST_DONE     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// What the back end must emit for one queued entry
	typedef enum logic [2:0] {
		K_PLAIN    = 3'd0,
		K_SHORT    = 3'd1,
		K_UNICODE  = 3'd2,
		K_DONE     = 3'd3,
		K_OVERFLOW = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       terminator;
	} char_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             run_last;
		status_t          status;
		logic [POS_W-1:0] position;
	} result_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
	} desc_t;

	// Number of transactions an entry expands to
	function automatic logic [SEQ_W-1:0] seq_len(kind_t kind);
		logic [SEQ_W-1:0] n;
		unique case (kind)
			K_SHORT:   n = SEQ_W'(2);
			K_UNICODE: n = SEQ_W'(ESC_MAX);
			default:   n = SEQ_W'(1);
		endcase
		return n;
	endfunction

	// Lower-case hex digit of a nibble
	function automatic logic [7:0] hex_digit(logic [3:0] v);
		logic [7:0] d;
		if (v < 4'd10) begin
			d = CH_ZERO + {4'h0, v};
		end else begin
			d = CH_LOW_A + {4'h0, v} - 8'd10;
		end
		return d;
	endfunction

endpackage

// ===== rtl/core/jse_stream_if.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper stream interface
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/json_string_escaper_unit.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper unit
// Escapes a character stream for a JSON string literal and tags each byte
// with its destination buffer index.
// ---------------------------------------------------------------------------
//  channel   | dir | payload                                        | handshake
//  chars     | in  | char_byte, terminator                          | valid/ready
//  results   | out | out_byte, byte_valid, run_last, status, position | valid/ready
//  apb       | in  | capacity (0x0), start position (0x4)           | psel/penable
//
//  A character is taken every cycle while the four-entry descriptor queue has
//  room; the back end emits one result per cycle while results.ready allows,
//  so a character costs 1, 2 or 6 results and the output channel sets the
//  sustained rate; results pass through the queue and the output register.
//  Reset clears string state, queue and output register; no clearing pass.
//  Output stalls back up into the queue, then into chars.ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_escaper_unit #(
	parameter int INDEX_BITS = jse_pkg::INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	jse_stream_if.sink                  chars,
	jse_stream_if.source                results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jse_pkg::APB_AW-1:0]  paddr,
	input  logic [jse_pkg::APB_DW-1:0]  pwdata,
	output logic [jse_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import jse_pkg::*;

	logic [CFG_W-1:0] capacity_q;
	logic [CFG_W-1:0] start_q;
	logic             cfg_wr;

	logic             push;
	desc_t            push_desc;
	logic             pop;
	desc_t            head;
	logic             queue_full;
	logic             queue_empty;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			start_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_CAPACITY: capacity_q <= pwdata[CFG_W-1:0];
				REG_START:    start_q    <= pwdata[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CAPACITY: prdata = APB_DW'(capacity_q);
			REG_START:    prdata = APB_DW'(start_q);
			default:      prdata = '0;
		endcase
	end

	// Classify and track string state
	jse_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chars.valid),
		.in_item    (chars.payload),
		.in_ready   (chars.ready),
		.capacity   (capacity_q),
		.start_pos  (start_q),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	// Decouple front and back
	jse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (push_desc),
		.rd     (pop),
		.rdata  (head),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// Expand descriptors into bytes
	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (queue_empty),
		.pop       (pop),
		.out_valid (results.valid),
		.out_item  (results.payload),
		.out_ready (results.ready)
	);

endmodule

// ===== rtl/core/jse_front.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper front end
// Accepts characters, tracks string state and pushes one descriptor per
// character or terminator that produces output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_front #(
	parameter int INDEX_BITS = jse_pkg::INDEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  jse_pkg::char_item_t        in_item,
	output logic                       in_ready,
	input  logic [jse_pkg::CFG_W-1:0]  capacity,
	input  logic [jse_pkg::CFG_W-1:0]  start_pos,
	input  logic                       queue_full,
	output logic                       push,
	output jse_pkg::desc_t             push_desc
);
	import jse_pkg::*;

	localparam int CMP_W = ((INDEX_BITS > CFG_W) ? INDEX_BITS : CFG_W) + 1;

	logic [INDEX_BITS-1:0] wp_q;
	logic                  in_string_q;
	logic                  ovf_q;

	logic                  accept;
	logic [INDEX_BITS-1:0] start_idx;
	logic [INDEX_BITS-1:0] eff_wp;
	logic                  eff_ovf;
	logic                  no_room;
	kind_t                 ch_kind;
	logic [7:0]            ch_data;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign start_idx = INDEX_BITS'(start_pos);
	assign eff_wp    = in_string_q ? wp_q : start_idx;
	assign eff_ovf   = in_string_q && ovf_q;
	assign no_room   = (CMP_W'(eff_wp) + CMP_W'(ESC_MAX)) >= CMP_W'(capacity);

	// Classify the character
	always_comb begin
		ch_data = in_item.char_byte;
		unique case (in_item.char_byte)
			CH_QUOTE, CH_BSLASH: ch_kind = K_SHORT;
			CH_BS: begin
				ch_kind = K_SHORT;
				ch_data = CH_LOW_B;
			end
			CH_FF: begin
				ch_kind = K_SHORT;
				ch_data = CH_LOW_F;
			end
			CH_LF: begin
				ch_kind = K_SHORT;
				ch_data = CH_LOW_N;
			end
			CH_CR: begin
				ch_kind = K_SHORT;
				ch_data = CH_LOW_R;
			end
			CH_TAB: begin
				ch_kind = K_SHORT;
				ch_data = CH_LOW_T;
			end
			default: begin
				ch_kind = (in_item.char_byte < CH_SPACE) ? K_UNICODE : K_PLAIN;
			end
		endcase
	end

	// Build the descriptor; dropped characters push nothing
	always_comb begin
		push_desc.pos  = POS_W'(eff_wp);
		push_desc.data = ch_data;
		if (in_item.terminator) begin
			push_desc.kind = eff_ovf ? K_OVERFLOW : K_DONE;
			push_desc.data = 8'h00;
		end else if (no_room) begin
			push_desc.kind = K_OVERFLOW;
			push_desc.data = 8'h00;
		end else begin
			push_desc.kind = ch_kind;
		end
	end

	assign push = accept && (in_item.terminator || !eff_ovf);

	// Advance string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			in_string_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (in_item.terminator) begin
				wp_q        <= eff_wp;
				in_string_q <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				in_string_q <= 1'b1;
				if (eff_ovf) begin
					wp_q  <= eff_wp;
					ovf_q <= 1'b1;
				end else if (no_room) begin
					wp_q  <= start_idx;
					ovf_q <= 1'b1;
				end else begin
					wp_q  <= eff_wp + INDEX_BITS'(seq_len(ch_kind));
					ovf_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/jse_queue.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper descriptor queue
// Small flip-flop FIFO decoupling the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_escaper_unit_defines.svh"

module jse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  jse_pkg::desc_t wdata,
	input  logic           rd,
	output jse_pkg::desc_t rdata,
	output logic           full,
	output logic           empty
);
	import jse_pkg::*;

	desc_t                  slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`JSE_ASSERT_NOW(a_no_push_full, wr, !full, "descriptor pushed into full queue")
	`JSE_ASSERT_NOW(a_no_pop_empty, rd, !empty, "descriptor popped from empty queue")
	`JSE_ASSERT_NOW(a_count_range, 1'b1, count_q <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/jse_back.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper back end
// Expands queued descriptors into escaped bytes, one per cycle unless the
// output stalls, through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_escaper_unit_defines.svh"

module jse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jse_pkg::desc_t        head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  out_valid,
	output jse_pkg::result_item_t out_item,
	input  logic                  out_ready
);
	import jse_pkg::*;

	logic [SEQ_W-1:0] idx_q;
	logic             out_valid_q;
	result_item_t     out_item_q;

	logic             load_ok;
	logic             fire;
	logic [SEQ_W-1:0] len;
	logic             last;
	result_item_t     next_item;

	assign load_ok = !out_valid_q || out_ready;
	assign fire    = load_ok && !empty;
	assign len     = seq_len(head.kind);
	assign last    = (idx_q == (len - 1'b1));
	assign pop     = fire && last;

	// Form the byte at the current step of the entry
	always_comb begin
		next_item.run_last   = last;
		next_item.position   = head.pos + POS_W'(idx_q);
		next_item.byte_valid = 1'b1;
		next_item.status     = ST_BYTE;
		next_item.out_byte   = 8'h00;
		case (head.kind)
			K_PLAIN: next_item.out_byte = head.data;
			K_SHORT: next_item.out_byte = (idx_q == '0) ? CH_BSLASH : head.data;
			K_UNICODE: begin
				case (idx_q)
					SEQ_W'(0): next_item.out_byte = CH_BSLASH;
					SEQ_W'(1): next_item.out_byte = CH_LOW_U;
					SEQ_W'(4): next_item.out_byte = hex_digit(head.data[7:4]);
					SEQ_W'(5): next_item.out_byte = hex_digit(head.data[3:0]);
					default:   next_item.out_byte = CH_ZERO;
				endcase
			end
			K_DONE: begin
				next_item.byte_valid = 1'b0;
				next_item.status     = ST_DONE;
			end
			default: begin
				next_item.byte_valid = 1'b0;
				next_item.status     = ST_OVERFLOW;
			end
		endcase
	end

	// Step through the entry and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			idx_q       <= last ? '0 : idx_q + 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= next_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`JSE_ASSERT_NOW(a_idx_in_entry, !empty, idx_q < len, "step index beyond entry length")
	`JSE_ASSERT_NOW(a_idx_needs_entry, idx_q != '0, !empty, "step index set with no entry")
	`JSE_ASSERT_NEXT(a_fire_loads, fire, out_valid_q, "output register not loaded")

endmodule

// ===== dv/jse_escape_checker.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper checker
// Watches the character, result and register channels, predicts the escaped
// byte stream with buffer positions and compares each result with the oldest
// prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_escape_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        chars_valid,
	input  logic                        chars_ready,
	input  jse_pkg::char_item_t         chars_payload,
	input  logic                        results_valid,
	input  logic                        results_ready,
	input  jse_pkg::result_item_t       results_payload,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [jse_pkg::APB_AW-1:0]  paddr,
	input  logic [jse_pkg::APB_DW-1:0]  pwdata,
	output int unsigned                 fail_count,
	output int unsigned                 pending
);
	import jse_pkg::*;

	localparam int unsigned MAX_REPORTS = 10;

	// Predicted results, oldest first
	result_item_t     escaped_q[$];

	// Shadow of the registers and the string state
	logic [CFG_W-1:0] capacity_reg;
	logic [CFG_W-1:0] start_reg;
	logic [POS_W-1:0] wr_pos;
	logic             in_str;
	logic             ovf_seen;

	char_item_t       item;
	result_item_t     exp_item;
	result_item_t     act_item;
	logic [5:0][7:0]  seq;
	int               seq_n;

	function automatic logic [7:0] nib_hex(logic [3:0] v);
		logic [7:0] d;
		if (v < 4'd10) begin
			d = CH_ZERO + 8'(v);
		end else begin
			d = CH_LOW_A + 8'(v) - 8'd10;
		end
		return d;
	endfunction

	// Escape sequence for one character
	function automatic void escape_char(input logic [7:0] c, output logic [5:0][7:0] s,
			output int n);
		s = '0;
		s[0] = CH_BSLASH;
		n = 2;
		case (c)
			CH_QUOTE, CH_BSLASH: s[1] = c;
			CH_BS:  s[1] = CH_LOW_B;
			CH_FF:  s[1] = CH_LOW_F;
			CH_LF:  s[1] = CH_LOW_N;
			CH_CR:  s[1] = CH_LOW_R;
			CH_TAB: s[1] = CH_LOW_T;
			default: begin
				if (c < CH_SPACE) begin
					s[1] = CH_LOW_U;
					s[2] = CH_ZERO;
					s[3] = CH_ZERO;
					s[4] = nib_hex(c[7:4]);
					s[5] = nib_hex(c[3:0]);
					n = ESC_MAX;
				end else begin
					s[0] = c;
					n = 1;
				end
			end
		endcase
	endfunction

	function automatic result_item_t mk_result(logic [7:0] b, logic v, logic l, status_t st,
			logic [POS_W-1:0] p);
		result_item_t r;
		r.out_byte   = b;
		r.byte_valid = v;
		r.run_last   = l;
		r.status     = st;
		r.position   = p;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_reg = '0;
			start_reg    = '0;
			wr_pos       = '0;
			in_str       = 1'b0;
			ovf_seen     = 1'b0;
			escaped_q.delete();
			fail_count   = 0;
			pending      = 0;
		end else begin
			// Retire a result transaction against the oldest prediction
			if (results_valid && results_ready) begin
				act_item = results_payload;
				if (escaped_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("unexpected result: byte %h valid %b last %b status %0d pos %0d",
							act_item.out_byte, act_item.byte_valid, act_item.run_last,
							act_item.status, act_item.position);
					end
				end else begin
					exp_item = escaped_q.pop_front();
					if (act_item.out_byte !== exp_item.out_byte
							|| act_item.byte_valid !== exp_item.byte_valid
							|| act_item.run_last !== exp_item.run_last
							|| act_item.status !== exp_item.status
							|| act_item.position !== exp_item.position) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("result mismatch: exp %h %b %b %0d %0d, got %h %b %b %0d %0d",
								exp_item.out_byte, exp_item.byte_valid, exp_item.run_last,
								exp_item.status, exp_item.position,
								act_item.out_byte, act_item.byte_valid, act_item.run_last,
								act_item.status, act_item.position);
						end
					end
				end
			end

			// Track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CAPACITY) begin
					capacity_reg = pwdata[CFG_W-1:0];
				end else begin
					start_reg = pwdata[CFG_W-1:0];
				end
			end

			// Predict the results of an accepted character transaction
			if (chars_valid && chars_ready) begin
				item = chars_payload;
				if (!in_str) begin
					wr_pos   = start_reg;
					ovf_seen = 1'b0;
				end
				if (item.terminator) begin
					escaped_q.push_back(mk_result(8'h00, 1'b0, 1'b1,
						ovf_seen ? ST_OVERFLOW : ST_DONE, wr_pos));
					in_str   = 1'b0;
					ovf_seen = 1'b0;
				end else begin
					in_str = 1'b1;
					// Drop the rest of a string once it has overflowed
					if (!ovf_seen) begin
						if (({1'b0, wr_pos} + 17'(ESC_MAX)) >= {1'b0, capacity_reg}) begin
							escaped_q.push_back(mk_result(8'h00, 1'b0, 1'b1, ST_OVERFLOW, wr_pos));
							ovf_seen = 1'b1;
							wr_pos   = start_reg;
						end else begin
							escape_char(item.char_byte, seq, seq_n);
							for (int i = 0; i < seq_n; i++) begin
								escaped_q.push_back(mk_result(seq[i], 1'b1, i == seq_n - 1,
									ST_BYTE, wr_pos + POS_W'(i)));
							end
							wr_pos = wr_pos + POS_W'(seq_n);
						end
					end
				end
			end

			pending = escaped_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper testbench
// Drives strings of characters and register settings into the escaper, with
// random idling on both channels, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import jse_pkg::*;

	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'h0;
	localparam logic [APB_AW-1:0] ADDR_START    = 3'h4;
	localparam int unsigned       CYCLE_LIMIT   = 400000;
	localparam int unsigned       DRAIN_CYCLES  = 8;
	localparam int unsigned       HOLD_CYCLES   = 64;
	localparam int unsigned       PHASE_ITEMS   = 12;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned snd_idle_pct = 19;
	int unsigned rcv_idle_pct = 80;
	int unsigned hold_req     = 0;
	int unsigned hold_seen    = 0;
	int unsigned hold_left    = 0;
	int unsigned cycle_cnt    = 0;
	int unsigned items_sent   = 0;

	logic [7:0] directed_chars [14] = '{8'h00, 8'h1F, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF,
		CH_LF, CH_CR, CH_TAB, 8'h2F, CH_SPACE, 8'h7F, 8'hFF, 8'h1A};

	jse_stream_if #(.payload_t(char_item_t))   chars_if ();
	jse_stream_if #(.payload_t(result_item_t)) results_if ();

	json_string_escaper_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	jse_escape_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.chars_valid     (chars_if.valid),
		.chars_ready     (chars_if.ready),
		.chars_payload   (chars_if.payload),
		.results_valid   (results_if.valid),
		.results_ready   (results_if.ready),
		.results_payload (results_if.payload),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			results_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			results_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_req;
		end else begin
			results_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Offer one character transaction and wait for it to be taken
	task automatic send_item(input logic [7:0] c, input logic term);
		logic taken;
		while ($urandom_range(99) < snd_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.payload <= char_item_t'({c, term});
		do begin
			@(negedge clk);
			taken = chars_if.ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	// One APB write; psel is left high for a following write
	task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
		logic done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
	endtask

	// Hold off until every result is out and the pipeline has drained
	task automatic settle();
		chars_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] start);
		settle();
		cfg_write(ADDR_CAPACITY, cap);
		cfg_write(ADDR_START, start);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Character mix weighted towards the escaped classes
	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		case ($urandom_range(9))
			0, 1: c = 8'($urandom_range(31));
			2: begin
				case ($urandom_range(2))
					0: c = CH_QUOTE;
					1: c = CH_BSLASH;
					default: c = 8'h2F;
				endcase
			end
			3, 4, 5, 6: c = 8'($urandom_range(8'h7E, 8'h20));
			default: c = 8'($urandom_range(255));
		endcase
		return c;
	endfunction

	task automatic send_string(input int unsigned max_len, input logic terminate);
		int unsigned len;
		len = $urandom_range(max_len);
		for (int unsigned i = 0; i < len; i++) begin
			send_item(rand_char(), 1'b0);
		end
		if (terminate) begin
			send_item(8'($urandom_range(255)), 1'b1);
		end
	endtask

	initial begin
		int unsigned phase_start;
		logic [CFG_W-1:0] cap;
		logic [CFG_W-1:0] start;

		chars_if.valid   = 1'b0;
		chars_if.payload = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty string, every escape class, slash passed through
		configure(16'd200, 16'd5);
		send_item(8'hA5, 1'b1);
		foreach (directed_chars[i]) begin
			send_item(directed_chars[i], 1'b0);
		end
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);

		// Overflow part way, dropped character, terminator reports start
		configure(16'd12, 16'd3);
		send_item(8'h61, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(8'h63, 1'b0);
		send_item(8'h00, 1'b1);

		// Zero capacity, and start at the top of the index range
		configure(16'd0, 16'd0);
		send_item(8'h78, 1'b0);
		send_item(8'h00, 1'b1);
		configure(16'hFFFF, 16'hFFFF);
		send_item(8'h79, 1'b0);
		send_item(8'h00, 1'b1);

		// Random strings over three idling regimes
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin snd_idle_pct = 19; rcv_idle_pct = 80; end
				1: begin snd_idle_pct = 80; rcv_idle_pct = 19; end
				default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			endcase
			for (int s = 0; s < 2; s++) begin
				case ($urandom_range(3))
					0: begin
						cap   = 16'($urandom_range(80, 20));
						start = 16'($urandom_range(15));
					end
					1: begin
						cap   = 16'hFFFF;
						start = 16'($urandom_range(16'hFFFF));
					end
					2: begin
						cap   = 16'($urandom_range(16'hFFFF));
						start = 16'($urandom_range(16'hFFFF));
					end
					default: begin
						cap   = 16'($urandom_range(400, 100));
						start = 16'h0000;
					end
				endcase
				configure(cap, start);
				// Stall the results while characters keep coming
				if (p == 2 && s == 0) begin
					hold_req++;
				end
				phase_start = items_sent;
				while (items_sent - phase_start < PHASE_ITEMS) begin
					if ($urandom_range(7) == 0) begin
						repeat ($urandom_range(3, 1)) begin
							send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
						end
					end else begin
						send_string(10, $urandom_range(3) != 0);
					end
				end
			end
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
